/* rtl/assert_macros.svh */
// Assertion helpers for the resampler RTL.
// Each macro takes a label, the clock, the synchronous reset and a property expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define RSVR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rsvr assertion failed");

// Same check, with a caller-supplied message string.
`define RSVR_ASSERT_MSG(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`else

`define RSVR_ASSERT(label, clk, rst, prop)
`define RSVR_ASSERT_MSG(label, clk, rst, prop, msg)

`endif

`endif

/* rtl/rsvr_pkg.sv */
package rsvr_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 26;
  localparam int INDEX_W     = 13;
  localparam int PLAY_W      = 31;
  localparam int STEP_W      = 12;
  localparam int GAIN_W      = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  // Position tracking
  localparam int ACC_W       = 32;
  localparam int PTR_W       = 32;
  localparam int FRAC_BITS   = 8;
  localparam int POS_W       = ACC_W - FRAC_BITS;
  localparam int MAX_WRITES  = 8;
  localparam int COUNT_W     = $clog2(MAX_WRITES + 1);

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAC_STEP,
    CFG_VOLUME_GAIN,
    CFG_SIXTEEN_BIT,
    CFG_STEREO_SOURCE
  } cfg_index_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_L,
    ST_MUL_R,
    ST_TEST,
    ST_LOOK,
    ST_EMIT
  } state_t;

  // Format and step settings seen by the sequencer
  typedef struct packed {
    logic [STEP_W-1:0] frac_step;
    logic              sixteen_bit;
    logic              stereo_source;
  } cfg_t;

  // Widen one raw channel to a signed 16-bit sample.
  // 8-bit signed: low byte moved to the top. 8-bit unsigned: offset 128 removed.
  function automatic logic signed [SAMPLE_W-1:0] sample_widen(
    input logic [SAMPLE_W-1:0] raw,
    input logic                sixteen,
    input logic                stereo
  );
    logic [SAMPLE_W-1:0] wide;
    if (sixteen) begin
      wide = raw;
    end else if (stereo) begin
      wide = {raw[7:0], 8'h00};
    end else begin
      wide = {~raw[7], raw[6:0], 8'h00};
    end
    return $signed(wide);
  endfunction

endpackage

/* rtl/pcm_resample_volume_ring_writer.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: first_frame; tdata: play_time,
//                                               left_raw, right_raw
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: ring_index, left_out, right_out;
//                                               tlast: last_of_run
// cfg       in   cfg_we (no wait)               cfg_index, cfg_data
//
// A frame makes from 0 to 8 ring writes; the sequencer walks them one write at a time
// through the shared gain multiplier.
// s_axis_tready is high only while the sequencer is idle.
// A stall on m_axis holds the current write and the sequencer until it is taken.
// rst is synchronous: position state clears, registers return to their defaults.
module pcm_resample_volume_ring_writer #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [rsvr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rsvr_pkg::CFG_DATA_W-1:0]     cfg_data,
  // source frames
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [63:0]                         s_axis_tdata,  // play_time, left_raw, right_raw
  input  logic                                s_axis_tuser,  // first_frame
  // ring writes
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [71:0]                         m_axis_tdata,  // ring_index, left_out, right_out
  output logic                                m_axis_tlast   // last_of_run
);
  import rsvr_pkg::*;

  logic [STEP_W-1:0]          frac_step;
  logic [GAIN_W-1:0]          volume_gain;
  logic                       sixteen_bit;
  logic                       stereo_source;
  cfg_t                       cfg;

  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [PROD_W-1:0]   mul_p;
  logic [INDEX_W-1:0]         out_index;
  logic signed [PROD_W-1:0]   out_left;
  logic signed [PROD_W-1:0]   out_right;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_step     <= STEP_W'(256);
      volume_gain   <= GAIN_W'(179);
      sixteen_bit   <= 1'b1;
      stereo_source <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAC_STEP:     frac_step     <= cfg_data[STEP_W-1:0];
        CFG_VOLUME_GAIN:   volume_gain   <= cfg_data[GAIN_W-1:0];
        CFG_SIXTEEN_BIT:   sixteen_bit   <= cfg_data[0];
        CFG_STEREO_SOURCE: stereo_source <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{frac_step: frac_step, sixteen_bit: sixteen_bit,
                 stereo_source: stereo_source};

  rsvr_mul u_mul (
    .clk     (clk),
    .sample  (mul_a),
    .gain    (volume_gain),
    .product (mul_p)
  );

  rsvr_seq #(
    .RING_DEPTH (RING_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_first     (s_axis_tuser),
    .in_play_time (s_axis_tdata[30:0]),
    .in_left      (s_axis_tdata[46:31]),
    .in_right     (s_axis_tdata[62:47]),
    .mul_a        (mul_a),
    .mul_p        (mul_p),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_index    (out_index),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_last     (m_axis_tlast)
  );

  // Pack the write, zero fill to whole bytes
  assign m_axis_tdata = {7'b0, out_right, out_left, out_index};

endmodule

/* rtl/rsvr_mul.sv */
// Shared gain multiplier: signed sample times unsigned gain, product registered.
module rsvr_mul (
  input  logic                                clk,
  input  logic signed [rsvr_pkg::SAMPLE_W-1:0] sample,
  input  logic        [rsvr_pkg::GAIN_W-1:0]   gain,
  output logic signed [rsvr_pkg::PROD_W-1:0]   product
);
  import rsvr_pkg::*;

  logic signed [SAMPLE_W+GAIN_W:0] prod_full;

  // Multiply with the gain zero-extended to a signed operand
  assign prod_full = sample * $signed({1'b0, gain});

  // Register the product, keep the 26-bit result
  always_ff @(posedge clk) begin
    product <= prod_full[PROD_W-1:0];
  end

endmodule

/* rtl/rsvr_seq.sv */
`include "assert_macros.svh"

// Frame sequencer: burst pull-up, sample widening, write loop over the 24.8 accumulator.
module rsvr_seq #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rsvr_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_first,
  input  logic        [rsvr_pkg::PLAY_W-1:0]   in_play_time,
  input  logic signed [rsvr_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [rsvr_pkg::SAMPLE_W-1:0] in_right,
  output logic signed [rsvr_pkg::SAMPLE_W-1:0] mul_a,
  input  logic signed [rsvr_pkg::PROD_W-1:0]   mul_p,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [rsvr_pkg::INDEX_W-1:0]  out_index,
  output logic signed [rsvr_pkg::PROD_W-1:0]   out_left,
  output logic signed [rsvr_pkg::PROD_W-1:0]   out_right,
  output logic                                 out_last
);
  import rsvr_pkg::*;

  localparam logic [PTR_W-1:0] RING_MASK = PTR_W'(RING_DEPTH - 1);

  state_t state, state_next;

  // Captured request
  logic                       first_q;
  logic [PLAY_W-1:0]          play_q;
  logic [SAMPLE_W-1:0]        left_q;
  logic [SAMPLE_W-1:0]        right_q;

  // Position state
  logic [PTR_W-1:0]           wp;
  logic [ACC_W-1:0]           acc;
  logic [POS_W-1:0]           fc;
  logic [COUNT_W-1:0]         count;

  logic signed [PROD_W-1:0]   left_prod;
  logic signed [SAMPLE_W-1:0] left16;
  logic signed [SAMPLE_W-1:0] right16;
  logic [POS_W-1:0]           pos_diff;
  logic                       reached;
  logic                       room;
  logic                       emit_go;
  logic                       pull_up;
  logic [PTR_W-1:0]           wp_masked;

  // Widen both channels; mono sources copy the left channel
  assign left16  = sample_widen(left_q, cfg.sixteen_bit, cfg.stereo_source);
  assign right16 = sample_widen(cfg.stereo_source ? right_q : left_q,
                                cfg.sixteen_bit, cfg.stereo_source);

  // Accumulator position against the frame, as a signed 24-bit difference
  assign pos_diff  = acc[ACC_W-1:FRAC_BITS] - fc;
  assign reached   = (pos_diff == '0) || pos_diff[POS_W-1];
  assign room      = count < COUNT_W'(MAX_WRITES);
  assign emit_go   = room && reached;
  assign pull_up   = wp[PTR_W-1] || (wp < {1'b0, play_q});
  assign wp_masked = wp & RING_MASK;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_TEST;
      ST_TEST:  state_next = emit_go ? ST_LOOK : ST_IDLE;
      ST_LOOK:  state_next = ST_EMIT;
      ST_EMIT:  if (out_ready) state_next = out_last ? ST_IDLE : ST_TEST;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    mul_a     = (state == ST_MUL_L) ? left16 : right16;
  end

  // Control state: pointer, accumulator, frame counter, write count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      acc   <= '0;
      fc    <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_PREP: begin
          count <= '0;
          if (first_q) begin
            if (pull_up) wp <= {1'b0, play_q};
            acc <= '0;
            fc  <= '0;
          end
        end
        ST_TEST: begin
          if (emit_go) begin
            wp    <= wp + 1'b1;
            acc   <= acc + ACC_W'(cfg.frac_step);
            count <= count + 1'b1;
          end else begin
            fc <= fc + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready && out_last) fc <= fc + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload: capture request, hold products, load the output register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          first_q <= in_first;
          play_q  <= in_play_time;
          left_q  <= in_left;
          right_q <= in_right;
        end
      end
      ST_MUL_R: left_prod <= mul_p;
      ST_TEST: begin
        if (emit_go) begin
          out_index <= wp_masked[INDEX_W-1:0];
          out_left  <= left_prod;
          out_right <= mul_p;
        end
      end
      // count and acc already advanced: mark last when no further write follows
      ST_LOOK: out_last <= !emit_go;
      default: ;
    endcase
  end

  `RSVR_ASSERT(a_no_overlap, clk, rst, !(in_ready && out_valid))
  `RSVR_ASSERT_MSG(a_count_bound, clk, rst, count <= COUNT_W'(MAX_WRITES),
                   "write count above limit")
  `RSVR_ASSERT_MSG(a_full_is_last, clk, rst,
                   (out_valid && count == COUNT_W'(MAX_WRITES)) |-> out_last,
                   "eighth write not marked last")
  `RSVR_ASSERT(a_more_retests, clk, rst,
               (out_valid && out_ready && !out_last) |=> (state == ST_TEST))

endmodule
